// File: hdl/tdg_pkg.sv
`timescale 1ns / 1ps

package tdg_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    FN_PRESSURE = 2'd0,
    FN_KEY      = 2'd1,
    FN_MOTION   = 2'd2,
    FN_TICK     = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic [2:0] CFG_ON_LEVEL      = 3'd0;
  localparam logic [2:0] CFG_OFF_LEVEL     = 3'd1;
  localparam logic [2:0] CFG_PRESSURE_ONLY = 3'd2;
  localparam logic [2:0] CFG_TAP_ENABLE    = 3'd3;
  localparam logic [2:0] CFG_TAP_TIMEOUT   = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // button result sequences produced by one item
  typedef enum logic [1:0] {
    PAT_PRESS         = 2'd0,  // press
    PAT_RELEASE       = 2'd1,  // release
    PAT_CLICK         = 2'd2,  // press, release
    PAT_RELEASE_CLICK = 2'd3   // release, press, release
  } pat_t;

  typedef struct packed {
    logic valid;
    pat_t pat;
  } push_t;

  typedef struct packed {
    logic [15:0] on_level;
    logic [15:0] off_level;
    logic        pressure_only;
    logic        tap_enable;
    logic [15:0] tap_timeout;
  } cfg_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// File: hdl/tap_drag_gesture_fsm.sv
`timescale 1ns / 1ps

// Touchpad tap and tap-and-drag detector driving the left button. Each input
// item is a pressure sample, a touch key level, a movement strobe or a 1 ms
// tick; each result item is one press (button_down 1) or release
// (button_down 0), with last set on the final result of an item. An item
// may give zero to three results. The front end takes one item per clock
// while in_ready is high and updates touch, motion, gesture and tap timer
// state in that cycle; items that cause button activity leave a result
// sequence in a two-entry queue. The back end plays sequences out back to
// back at one result per clock while out_ready is high: an accepted item's
// sequence is first written to the queue and then loaded into the back end
// busy register, which raises out_valid for its first result. Items with
// no results never enter the queue. in_ready drops only while it is full.
// Configuration is taken on the cfg_we strobe and should only be changed
// while no results are pending.

module tap_drag_gesture_fsm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_func,
  input  logic [15:0]                      in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_button_down,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [tdg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tdg_pkg::cfg_t  cfg_r;
  tdg_pkg::push_t push;
  tdg_pkg::pat_t  q_pat;
  logic           q_full, q_vld, pop;
  logic           acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_level      <= 16'd30;
      cfg_r.off_level     <= 16'd25;
      cfg_r.pressure_only <= 1'b1;
      cfg_r.tap_enable    <= 1'b1;
      cfg_r.tap_timeout   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        tdg_pkg::CFG_ON_LEVEL:      cfg_r.on_level      <= cfg_wdata;
        tdg_pkg::CFG_OFF_LEVEL:     cfg_r.off_level     <= cfg_wdata;
        tdg_pkg::CFG_PRESSURE_ONLY: cfg_r.pressure_only <= cfg_wdata[0];
        tdg_pkg::CFG_TAP_ENABLE:    cfg_r.tap_enable    <= cfg_wdata[0];
        tdg_pkg::CFG_TAP_TIMEOUT:   cfg_r.tap_timeout   <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // front end never pushes more than one sequence per item, so a free
  // queue slot is all it needs to accept
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  tdg_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .func  (in_func),
    .value (in_value),
    .cfg   (cfg_r),
    .push  (push)
  );

  tdg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .q_vld (q_vld),
    .q_pat (q_pat)
  );

  tdg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_pat           (q_pat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_button_down (out_button_down),
    .out_last        (out_last)
  );

endmodule

// File: hdl/tdg_front.sv
`timescale 1ns / 1ps

module tdg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          func,
  input  logic [15:0]         value,
  input  tdg_pkg::cfg_t       cfg,
  output tdg_pkg::push_t      push
);

  typedef enum logic [2:0] {
    GS_IDLE  = 3'd0,
    GS_TOUCH = 3'd1,
    GS_TAP   = 3'd2,
    GS_TAP2  = 3'd3,
    GS_DRAG  = 3'd4
  } gstate_t;

  typedef enum logic [1:0] {
    EV_TOUCH   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOTION  = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  logic        touching_r, touching_nxt;
  logic        moved_r, moved_nxt;
  gstate_t     gs_r, gs_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] count_r, count_nxt;

  logic ev_vld;
  ev_t  ev;
  logic arm;

  always_comb begin
    touching_nxt = touching_r;
    moved_nxt    = moved_r;
    gs_nxt       = gs_r;
    armed_nxt    = armed_r;
    count_nxt    = count_r;
    ev_vld       = 1'b0;
    ev           = EV_TOUCH;
    arm          = 1'b0;
    push.valid   = 1'b0;
    push.pat     = tdg_pkg::PAT_PRESS;

    // event extraction
    case (tdg_pkg::func_t'(func))
      tdg_pkg::FN_PRESSURE: begin
        if (value > cfg.on_level && !touching_r) begin
          ev_vld = 1'b1;
          ev     = EV_TOUCH;
        end else if (value < cfg.off_level && touching_r) begin
          ev_vld = 1'b1;
          ev     = EV_RELEASE;
        end
      end
      tdg_pkg::FN_KEY: begin
        if (!cfg.pressure_only) begin
          if (value != 16'd0 && !touching_r) begin
            ev_vld = 1'b1;
            ev     = EV_TOUCH;
          end else if (value == 16'd0) begin
            ev_vld = 1'b1;
            ev     = EV_RELEASE;
          end
        end
      end
      tdg_pkg::FN_MOTION: begin
        if (!moved_r) begin
          moved_nxt = 1'b1;
          ev_vld    = 1'b1;
          ev        = EV_MOTION;
        end
      end
      default: begin
        if (armed_r) begin
          if (count_r <= 16'd1) begin
            armed_nxt = 1'b0;
            count_nxt = 16'd0;
            ev_vld    = 1'b1;
            ev        = EV_TIMEOUT;
          end else begin
            count_nxt = count_r - 16'd1;
          end
        end
      end
    endcase

    if (ev_vld && ev == EV_TOUCH) begin
      touching_nxt = 1'b1;
    end
    if (ev_vld && ev == EV_RELEASE) begin
      touching_nxt = 1'b0;
      moved_nxt    = 1'b0;
    end

    // gesture machine
    if (ev_vld && cfg.tap_enable) begin
      case (gs_r)
        GS_IDLE: begin
          if (ev == EV_TOUCH) begin
            gs_nxt = GS_TOUCH;
          end
        end
        GS_TOUCH: begin
          if (ev == EV_RELEASE) begin
            arm    = 1'b1;
            gs_nxt = GS_TAP;
          end else begin
            gs_nxt = GS_IDLE;
          end
        end
        GS_TAP: begin
          if (ev == EV_TIMEOUT) begin
            push.valid = 1'b1;
            push.pat   = tdg_pkg::PAT_CLICK;
            gs_nxt     = GS_IDLE;
          end else if (ev == EV_TOUCH) begin
            push.valid = 1'b1;
            push.pat   = tdg_pkg::PAT_PRESS;
            gs_nxt     = GS_TAP2;
          end else begin
            gs_nxt = GS_IDLE;
          end
        end
        GS_TAP2: begin
          if (ev == EV_MOTION) begin
            gs_nxt = GS_DRAG;
          end else if (ev == EV_RELEASE) begin
            push.valid = 1'b1;
            push.pat   = tdg_pkg::PAT_RELEASE_CLICK;
            gs_nxt     = GS_IDLE;
          end else begin
            gs_nxt = GS_IDLE;
          end
        end
        GS_DRAG: begin
          if (ev == EV_RELEASE) begin
            push.valid = 1'b1;
            push.pat   = tdg_pkg::PAT_RELEASE;
          end
          gs_nxt = GS_IDLE;
        end
        default: begin
          gs_nxt = GS_IDLE;
        end
      endcase
      // any handled event disarms, except the early release
      if (arm) begin
        armed_nxt = 1'b1;
        count_nxt = cfg.tap_timeout;
      end else begin
        armed_nxt = 1'b0;
        count_nxt = 16'd0;
      end
    end

    push.valid = push.valid & acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touching_r <= 1'b0;
      moved_r    <= 1'b0;
      gs_r       <= GS_IDLE;
      armed_r    <= 1'b0;
      count_r    <= 16'd0;
    end else if (acc) begin
      touching_r <= touching_nxt;
      moved_r    <= moved_nxt;
      gs_r       <= gs_nxt;
      armed_r    <= armed_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// File: hdl/tdg_queue.sv
`timescale 1ns / 1ps

module tdg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  tdg_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output logic           q_vld,
  output tdg_pkg::pat_t  q_pat
);

  tdg_pkg::pat_t                mem_r [tdg_pkg::QDEPTH];
  logic [tdg_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tdg_pkg::QCNT_W-1:0]   cnt_r;

  localparam logic [tdg_pkg::QCNT_W-1:0] CNT_MAX = tdg_pkg::QCNT_W'(tdg_pkg::QDEPTH);
  localparam logic [tdg_pkg::QPTR_W-1:0] PTR_MAX = tdg_pkg::QPTR_W'(tdg_pkg::QDEPTH - 1);

  logic do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign q_vld   = (cnt_r != '0);
  assign q_pat   = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.pat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/tdg_back.sv
`timescale 1ns / 1ps

module tdg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_vld,
  input  tdg_pkg::pat_t q_pat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_button_down,
  output logic          out_last
);

  logic          busy_r;
  tdg_pkg::pat_t pat_r;
  logic [1:0]    step_r;
  logic          fire, done;

  always_comb begin
    out_button_down = 1'b0;
    out_last        = 1'b1;
    case (pat_r)
      tdg_pkg::PAT_PRESS: begin
        out_button_down = 1'b1;
      end
      tdg_pkg::PAT_RELEASE: begin
        out_button_down = 1'b0;
      end
      tdg_pkg::PAT_CLICK: begin
        out_button_down = (step_r == 2'd0);
        out_last        = (step_r == 2'd1);
      end
      tdg_pkg::PAT_RELEASE_CLICK: begin
        out_button_down = (step_r == 2'd1);
        out_last        = (step_r == 2'd2);
      end
      default: begin
        out_button_down = 1'b0;
      end
    endcase
  end

  assign out_valid = busy_r;
  assign fire      = busy_r && out_ready;
  assign done      = fire && out_last;
  assign pop       = q_vld && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else if (!busy_r || done) begin
      busy_r <= q_vld;
      step_r <= 2'd0;
      if (q_vld) begin
        pat_r <= q_pat;
      end
    end else if (fire) begin
      step_r <= step_r + 2'd1;
    end
  end

endmodule

// File: hdl/tdg_checker.sv
`timescale 1ns / 1ps

module tdg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_button_down,
  input logic out_last
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("out_valid dropped before acceptance");

  // a sequence is delivered without gaps
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a result sequence");

  // within a sequence press and release alternate
  a_burst_alt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_button_down != $past(out_button_down)))
    else $error("button level repeated inside a sequence");

  // nothing pending right out of reset
  a_rst_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_rst_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind tap_drag_gesture_fsm tdg_checker u_tdg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_button_down (out_button_down),
  .out_last        (out_last)
);
